FILE: rtl/core/lbi_pkg.sv
// ----------------------------------------------------------------------------
// lbi_pkg
// Shared types, opcode and action codes for the init bytecode interpreter.
// ----------------------------------------------------------------------------
`default_nettype none

package lbi_pkg;

  localparam int OPCODE_BITS_DEFAULT = 3;
  localparam int COUNT_BITS_DEFAULT  = 5;

  localparam int BYTE_W   = 8;
  localparam int ACTION_W = 3;
  localparam int REPEAT_W = 6;
  localparam int DATA_W   = BYTE_W + REPEAT_W;
  localparam int M_TDATA_W = ((DATA_W + 7) / 8) * 8;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [BYTE_W-1:0] NIBBLE_MASK = 8'h0f;

  // instruction opcodes
  localparam logic [3:0] OPC_NOP    = 4'd0;
  localparam logic [3:0] OPC_IO     = 4'd1;
  localparam logic [3:0] OPC_DLY_US = 4'd2;
  localparam logic [3:0] OPC_DLY_MS = 4'd3;
  localparam logic [3:0] OPC_NIB    = 4'd4;
  localparam logic [3:0] OPC_CMD    = 4'd5;
  localparam logic [3:0] OPC_DAT    = 4'd6;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SET_IO   = 3'd0,
    ACT_CMD4     = 3'd1,
    ACT_DELAY_US = 3'd2,
    ACT_DELAY_MS = 3'd3,
    ACT_CMD8     = 3'd4,
    ACT_DAT8     = 3'd5
  } action_t;

  typedef struct packed {
    logic [REPEAT_W-1:0] repeat_count;
    logic [BYTE_W-1:0]   action_value;
    action_t             action;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/lcd_init_bytecode_interpreter_unit.sv
// ----------------------------------------------------------------------------
// lcd_init_bytecode_interpreter_unit
// Display init byte-stream interpreter: decoder, item queue, output register.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, set by the combinational decode and counter
//   update in the front stage; input stalls only while the 2-entry queue is full.
// Path: each action is written into the queue on the byte transfer and loaded
//   into the output register once that register is free to take it.
// Reset: synchronous, clears pending opcode, count, queue pointers, tvalid.
`default_nettype none

module lcd_init_bytecode_interpreter_unit #(
  parameter int OPCODE_BITS = lbi_pkg::OPCODE_BITS_DEFAULT,
  parameter int COUNT_BITS  = lbi_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [lbi_pkg::BYTE_W-1:0]    s_axis_tdata,  // [7:0] instruction_byte
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [7:0] action_value, [13:8] repeat_count, rest zero
  output logic [lbi_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  output logic [lbi_pkg::ACTION_W-1:0]       m_axis_tuser   // [2:0] action
);

  lbi_pkg::q_status_t q_stat;
  lbi_pkg::item_t     push_item;
  lbi_pkg::item_t     head_item;
  logic               push;
  logic               pop;

  lbi_front #(
    .OPCODE_BITS (OPCODE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  lbi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_stat    (q_stat)
  );

  lbi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head_item (head_item),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_repeat_one: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != lbi_pkg::ACT_DELAY_US)
                   && (m_axis_tuser != lbi_pkg::ACT_DELAY_MS))
      |-> (m_axis_tdata[13:8] == 6'd1))
    else $error("non-delay action with repeat other than one");

endmodule

`default_nettype wire

FILE: rtl/core/lbi_front.sv
// ----------------------------------------------------------------------------
// lbi_front
// Accepts instruction bytes, tracks the pending opcode and produces actions.
// ----------------------------------------------------------------------------
`default_nettype none

module lbi_front #(
  parameter int OPCODE_BITS = lbi_pkg::OPCODE_BITS_DEFAULT,
  parameter int COUNT_BITS  = lbi_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [lbi_pkg::BYTE_W-1:0] in_byte,
  input  wire lbi_pkg::q_status_t        q_stat,
  output logic                           push,
  output lbi_pkg::item_t                 push_item
);

  localparam logic [OPCODE_BITS-1:0] C_NOP      = OPCODE_BITS'(lbi_pkg::OPC_NOP);
  localparam logic [OPCODE_BITS-1:0] C_SET_IO   = OPCODE_BITS'(lbi_pkg::OPC_IO);
  localparam logic [OPCODE_BITS-1:0] C_DELAY_US = OPCODE_BITS'(lbi_pkg::OPC_DLY_US);
  localparam logic [OPCODE_BITS-1:0] C_DELAY_MS = OPCODE_BITS'(lbi_pkg::OPC_DLY_MS);
  localparam logic [OPCODE_BITS-1:0] C_CMD_4    = OPCODE_BITS'(lbi_pkg::OPC_NIB);
  localparam logic [OPCODE_BITS-1:0] C_CMD_8    = OPCODE_BITS'(lbi_pkg::OPC_CMD);
  localparam logic [OPCODE_BITS-1:0] C_DAT_8    = OPCODE_BITS'(lbi_pkg::OPC_DAT);

  logic [OPCODE_BITS-1:0] pending_opcode, pending_opcode_next;
  logic [COUNT_BITS-1:0]  remaining_count, remaining_count_next;

  logic [15:0]            byte_ext;
  logic [OPCODE_BITS-1:0] op;
  logic [COUNT_BITS-1:0]  cnt;
  logic                   accept;
  logic                   emit;
  lbi_pkg::item_t         item;

  // opcode bits above the byte read as zero
  assign byte_ext = {8'd0, in_byte};
  assign op       = byte_ext[COUNT_BITS +: OPCODE_BITS];
  assign cnt      = in_byte[COUNT_BITS-1:0];

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pending_opcode_next  = pending_opcode;
    remaining_count_next = remaining_count;
    emit                 = 1'b0;
    item.action          = lbi_pkg::ACT_SET_IO;
    item.action_value    = in_byte;
    item.repeat_count    = lbi_pkg::REPEAT_W'(1);
    unique case (pending_opcode) inside
      C_NOP: begin
        unique case (op) inside
          C_SET_IO: begin
            emit              = 1'b1;
            item.action       = lbi_pkg::ACT_SET_IO;
            item.action_value = lbi_pkg::BYTE_W'(cnt);
          end
          C_CMD_4: begin
            emit              = 1'b1;
            item.action       = lbi_pkg::ACT_CMD4;
            item.action_value = lbi_pkg::BYTE_W'(cnt) & lbi_pkg::NIBBLE_MASK;
          end
          C_DELAY_US, C_DELAY_MS, C_CMD_8, C_DAT_8: begin
            pending_opcode_next  = op;
            remaining_count_next = cnt;
          end
          default: ;
        endcase
      end
      C_DELAY_US, C_DELAY_MS: begin
        emit                 = 1'b1;
        item.action          = (pending_opcode == C_DELAY_US) ? lbi_pkg::ACT_DELAY_US
                                                              : lbi_pkg::ACT_DELAY_MS;
        item.repeat_count    = lbi_pkg::REPEAT_W'(remaining_count) + lbi_pkg::REPEAT_W'(1);
        pending_opcode_next  = C_NOP;
        remaining_count_next = '0;
      end
      C_CMD_8, C_DAT_8: begin
        emit        = 1'b1;
        item.action = (pending_opcode == C_CMD_8) ? lbi_pkg::ACT_CMD8 : lbi_pkg::ACT_DAT8;
        if (remaining_count != '0) begin
          remaining_count_next = remaining_count - COUNT_BITS'(1);
        end else begin
          pending_opcode_next  = C_NOP;
          remaining_count_next = '0;
        end
      end
      default: begin
        pending_opcode_next  = C_NOP;
        remaining_count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_opcode  <= C_NOP;
      remaining_count <= '0;
    end else if (accept) begin
      pending_opcode  <= pending_opcode_next;
      remaining_count <= remaining_count_next;
    end
  end

  assign push      = accept && emit;
  assign push_item = item;

endmodule

`default_nettype wire

FILE: rtl/core/lbi_queue.sv
// ----------------------------------------------------------------------------
// lbi_queue
// Short FIFO of action items between the decoder and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lbi_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire lbi_pkg::item_t push_item,
  input  wire logic           pop,
  output lbi_pkg::item_t      head_item,
  output lbi_pkg::q_status_t  q_stat
);

  lbi_pkg::item_t mem [lbi_pkg::QDEPTH];

  logic [lbi_pkg::QAW-1:0] wr_ptr;
  logic [lbi_pkg::QAW-1:0] rd_ptr;
  logic [lbi_pkg::QAW:0]   fill;

  assign q_stat.empty = (fill == '0);
  assign q_stat.full  = (fill == (lbi_pkg::QAW+1)'(lbi_pkg::QDEPTH));
  assign head_item    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + lbi_pkg::QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + lbi_pkg::QAW'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + (lbi_pkg::QAW+1)'(1);
        2'b01:   fill <= fill - (lbi_pkg::QAW+1)'(1);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lbi_back.sv
// ----------------------------------------------------------------------------
// lbi_back
// Output register: pulls items from the queue and presents them downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module lbi_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lbi_pkg::q_status_t            q_stat,
  input  wire lbi_pkg::item_t                head_item,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [lbi_pkg::M_TDATA_W-1:0]      out_data,
  output logic [lbi_pkg::ACTION_W-1:0]       out_user
);

  lbi_pkg::item_t out_item;

  assign pop      = !q_stat.empty && (!out_valid || out_ready);
  assign out_data = lbi_pkg::M_TDATA_W'({out_item.repeat_count, out_item.action_value});
  assign out_user = out_item.action;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= head_item;
    end
  end

endmodule

`default_nettype wire

FILE: test/init_bytecode_checker.sv
// ----------------------------------------------------------------------------
// init_bytecode_checker
// Watches both stream channels of the init bytecode interpreter. It decodes
// every byte accepted on the input into the display action, if any, that it
// should cause. Each action accepted on the output is compared, field by
// field, with the oldest one still waiting.
// ----------------------------------------------------------------------------
module init_bytecode_checker
  import lbi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [M_TDATA_W-1:0] out_data,
  input  logic [ACTION_W-1:0]  out_user,
  output int                   errors,
  output int                   actions_waiting,
  output int                   bytes_seen,
  output int                   actions_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OPCODE_BITS = OPCODE_BITS_DEFAULT;
  localparam int COUNT_BITS  = COUNT_BITS_DEFAULT;

  logic [3:0]            pending_op;
  logic [COUNT_BITS-1:0] left_cnt;
  item_t                 action_queue[$];

  function automatic bit interpret_byte(input logic [BYTE_W-1:0] b, output item_t act);
    logic [3:0]            op;
    logic [COUNT_BITS-1:0] cnt;
    op  = 4'((b >> COUNT_BITS) & ((1 << OPCODE_BITS) - 1));
    cnt = b[COUNT_BITS-1:0];
    act = '0;
    act.repeat_count = REPEAT_W'(1);
    interpret_byte = 1'b0;
    case (pending_op)
      OPC_NOP: begin
        case (op)
          OPC_IO: begin
            act.action       = ACT_SET_IO;
            act.action_value = BYTE_W'(cnt);
            interpret_byte   = 1'b1;
          end
          OPC_NIB: begin
            act.action       = ACT_CMD4;
            act.action_value = BYTE_W'(cnt) & NIBBLE_MASK;
            interpret_byte   = 1'b1;
          end
          OPC_DLY_US, OPC_DLY_MS, OPC_CMD, OPC_DAT: begin
            pending_op = op;
            left_cnt   = cnt;
          end
          default: ;
        endcase
      end
      OPC_DLY_US, OPC_DLY_MS: begin
        act.action       = (pending_op == OPC_DLY_US) ? ACT_DELAY_US : ACT_DELAY_MS;
        act.action_value = b;
        act.repeat_count = REPEAT_W'(left_cnt) + REPEAT_W'(1);
        interpret_byte   = 1'b1;
        pending_op       = OPC_NOP;
        left_cnt         = '0;
      end
      OPC_CMD, OPC_DAT: begin
        act.action       = (pending_op == OPC_CMD) ? ACT_CMD8 : ACT_DAT8;
        act.action_value = b;
        interpret_byte   = 1'b1;
        if (left_cnt != '0) begin
          left_cnt = left_cnt - 1'b1;
        end else begin
          pending_op = OPC_NOP;
        end
      end
      default: begin
        pending_op = OPC_NOP;
        left_cnt   = '0;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    item_t got;
    item_t want;
    if (rst) begin
      pending_op = OPC_NOP;
      left_cnt   = '0;
      action_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        actions_seen++;
        got.action       = action_t'(out_user);
        got.action_value = out_data[BYTE_W-1:0];
        got.repeat_count = out_data[BYTE_W +: REPEAT_W];
        if (action_queue.size() == 0) begin
          errors++;
          $error("unexpected action transfer: action %0d value 0x%02h repeat %0d",
                 got.action, got.action_value, got.repeat_count);
        end else begin
          want = action_queue.pop_front();
          if (got.action !== want.action) begin
            errors++;
            $error("action: expected %0d, got %0d", want.action, got.action);
          end
          if (got.action_value !== want.action_value) begin
            errors++;
            $error("action_value: expected 0x%02h, got 0x%02h",
                   want.action_value, got.action_value);
          end
          if (got.repeat_count !== want.repeat_count) begin
            errors++;
            $error("repeat_count: expected %0d, got %0d", want.repeat_count, got.repeat_count);
          end
          if (out_data[M_TDATA_W-1:DATA_W] !== '0) begin
            errors++;
            $error("padding: expected 0, got 0x%0h", out_data[M_TDATA_W-1:DATA_W]);
          end
        end
      end
      if (in_valid && in_ready) begin
        bytes_seen++;
        if (interpret_byte(in_data, want)) begin
          action_queue.push_back(want);
        end
      end
    end
    actions_waiting = action_queue.size();
  end

endmodule

FILE: test/lcd_init_bytecode_interpreter_unit_tb.sv
// ----------------------------------------------------------------------------
// lcd_init_bytecode_interpreter_unit_tb
// Sends a directed set of instruction and operand bytes and then random
// instruction sequences with noise bytes, under random idling on both sides
// and one long output stall. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module lcd_init_bytecode_interpreter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbi_pkg::*;

  localparam int RANDOM_ITEMS   = 1200;
  localparam int STALL_CYCLES   = 400;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [BYTE_W-1:0]    s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [ACTION_W-1:0]  m_axis_tuser;

  int errors;
  int actions_waiting;
  int bytes_seen;
  int actions_seen;
  int stuck_cycles;
  bit steady;
  bit hold_req;
  bit hold_done;

  always #5 clk = ~clk;

  lcd_init_bytecode_interpreter_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  init_bytecode_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .in_data         (s_axis_tdata),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_data        (m_axis_tdata),
    .out_user        (m_axis_tuser),
    .errors          (errors),
    .actions_waiting (actions_waiting),
    .bytes_seen      (bytes_seen),
    .actions_seen    (actions_seen)
  );

  function automatic logic [BYTE_W-1:0] instr(input logic [3:0] op, input logic [4:0] cnt);
    return {op[2:0], cnt};
  endfunction

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    bit rdy;
    if (!steady && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do begin
      @(negedge clk);
      rdy = s_axis_tready;
      @(posedge clk);
    end while (!rdy);
  endtask

  // one instruction with its operands, or a stray byte; returns bytes sent
  task automatic random_sequence(output int counted);
    logic [3:0] op;
    logic [4:0] cnt;
    op  = 4'($urandom_range(7));
    cnt = 5'($urandom);
    counted = 0;
    if ($urandom_range(99) < 12) begin
      push_byte(BYTE_W'($urandom));
      counted = 1;
    end else begin
      case (op)
        OPC_DLY_US, OPC_DLY_MS: begin
          push_byte(instr(op, cnt));
          push_byte(BYTE_W'($urandom));
          counted = 2;
        end
        OPC_CMD, OPC_DAT: begin
          if ($urandom_range(9) != 0) cnt = 5'($urandom_range(3));
          push_byte(instr(op, cnt));
          repeat (int'(cnt) + 1) push_byte(BYTE_W'($urandom));
          counted = int'(cnt) + 2;
        end
        OPC_IO, OPC_NIB: begin
          push_byte(instr(op, cnt));
          counted = 1;
        end
        default: begin
          push_byte(instr(op, cnt));
          counted = 1;
        end
      endcase
    end
  endtask

  // output side: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 7);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("[lcd_init_bytecode_interpreter_unit] ERROR");
      $finish;
    end
  end

  initial begin
    logic [BYTE_W-1:0] directed[$];
    int sent;
    int n;
    directed = '{
      instr(OPC_IO, 5'd0), instr(OPC_IO, 5'h1f),
      instr(OPC_NIB, 5'h1f), instr(OPC_NIB, 5'h0a),
      instr(OPC_NOP, 5'h15), 8'he0, 8'hff,                 // nop, unknown opcode
      instr(OPC_DLY_US, 5'd0), 8'h00,
      instr(OPC_DLY_MS, 5'h1f), 8'hff,                     // longest repeat
      instr(OPC_CMD, 5'd0), instr(OPC_IO, 5'd3),           // operand looks like an opcode
      instr(OPC_DAT, 5'd2), 8'hff, 8'h00, 8'ha5,
      instr(OPC_DLY_US, 5'd7), instr(OPC_CMD, 5'd1),
      instr(OPC_IO, 5'd9)
    };
    sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) push_byte(directed[i]);

    while (sent < RANDOM_ITEMS) begin
      steady = (sent >= 300) && (sent < 600);
      if (sent >= 700) hold_req = 1'b1;
      random_sequence(n);
      sent += n;
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (actions_waiting != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d instruction bytes and %0d display actions,", bytes_seen,
             actions_seen);
    $display("  all opcodes, stray and unknown bytes, and a %0d-cycle output stall.",
             STALL_CYCLES);
    if (errors == 0) begin
      $display("[lcd_init_bytecode_interpreter_unit] OK");
    end else begin
      $display("[lcd_init_bytecode_interpreter_unit] ERROR");
    end
    $finish;
  end

endmodule
